@@ design/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, quiet while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked assertion that also holds through reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ design/fbpa_pkg.sv @@
// types and constants of the fixed block pool allocator
package fbpa_pkg;

    localparam int INDEX_W     = 8;
    localparam int COUNT_W     = 9;
    localparam int INDEX_SPACE = 256;

    // request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_EMPTY      = 2'd1;
    localparam logic [1:0] STATUS_NOT_IN_USE = 2'd2;
    localparam logic [1:0] STATUS_RANGE      = 2'd3;

    typedef struct packed {
        logic               opcode;
        logic [INDEX_W-1:0] block_index;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [INDEX_W-1:0] granted_index;
        logic [COUNT_W-1:0] available_count;
        logic [COUNT_W-1:0] used_count;
    } out_beat_t;

    // one entry of the block table: in-use mark and free-list link
    typedef struct packed {
        logic               in_use;
        logic [INDEX_W-1:0] link;
    } blk_word_t;

    // write port of the block table
    typedef struct packed {
        logic               en;
        logic [INDEX_W-1:0] addr;
        blk_word_t          data;
    } blk_wr_t;

endpackage

@@ design/fixed_block_pool_allocator.sv @@
// top level of the fixed block pool allocator
//
//  channel  | ports                         | beat
//  ---------+-------------------------------+----------------------------------
//  request  | s_valid s_ready s_data        | opcode, block_index
//  result   | m_valid m_ready m_data        | status, granted, available, used
//  config   | cfg_wr_en cfg_wr_data         | block_count, no wait
//
// a request first reads the block table entry (link at the list head for allocate,
// mark at the index for free), then updates it
// a result held by a stalled m_ready keeps the next request in its update cycle
// a request beat is taken while an earlier result still waits in the output register
// reset is synchronous; no clearing pass, marks from the watermark up read as free
module fixed_block_pool_allocator
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  in_beat_t            s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output out_beat_t           m_data,
    input  logic                cfg_wr_en,
    input  logic [COUNT_W-1:0]  cfg_wr_data
);

    localparam logic [COUNT_W-1:0] CAP = (MAX_BLOCKS > INDEX_SPACE) ?
        COUNT_W'(INDEX_SPACE) : COUNT_W'(MAX_BLOCKS);

    typedef enum logic {ST_IDLE, ST_EXEC} state_t;

    state_t             state_reg;
    logic               op_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic [COUNT_W-1:0] block_count_reg;
    logic [INDEX_W-1:0] head_reg, head_next;
    logic               nonempty_reg, nonempty_next;
    logic [COUNT_W-1:0] watermark_reg, watermark_next;
    logic [COUNT_W-1:0] free_total_reg, free_total_next;
    logic               m_valid_reg;
    out_beat_t          m_data_reg, m_data_next;

    logic               accept;
    logic               fire;
    logic [INDEX_W-1:0] rd_addr;
    blk_word_t          word;
    blk_wr_t            wr;
    logic [COUNT_W-1:0] cfg_count;
    logic [INDEX_W-1:0] blk;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign fire    = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // allocate reads the head entry, free reads the entry it returns
    assign rd_addr = (s_data.opcode == OP_ALLOC) ? head_reg : s_data.block_index;

    fbpa_ram u_ram (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .wr      (wr),
        .rd_data (word)
    );

    // block count written: zero taken as one, saturated at the cap
    always_comb begin
        cfg_count = cfg_wr_data;
        if (cfg_wr_data == '0) begin
            cfg_count = COUNT_W'(1);
        end else if (cfg_wr_data > CAP) begin
            cfg_count = CAP;
        end
    end

    // request decode and pool update
    always_comb begin
        head_next       = head_reg;
        nonempty_next   = nonempty_reg;
        watermark_next  = watermark_reg;
        free_total_next = free_total_reg;
        blk             = '0;
        wr              = '0;
        m_data_next     = '0;
        m_data_next.status = STATUS_OK;
        if (op_reg == OP_ALLOC) begin
            if (free_total_reg == '0) begin
                m_data_next.status = STATUS_EMPTY;
            end else begin
                free_total_next = free_total_reg - COUNT_W'(1);
                if (nonempty_reg) begin
                    // pop the list head
                    blk           = head_reg;
                    head_next     = word.link;
                    nonempty_next = free_total_next > (block_count_reg - watermark_reg);
                end else begin
                    // untouched block from the watermark
                    blk            = watermark_reg[INDEX_W-1:0];
                    watermark_next = watermark_reg + COUNT_W'(1);
                end
                wr.en          = fire;
                wr.addr        = blk;
                wr.data.in_use = 1'b1;
                wr.data.link   = word.link;
                m_data_next.granted_index = blk;
            end
        end else begin
            if ({1'b0, idx_reg} >= block_count_reg) begin
                m_data_next.status = STATUS_RANGE;
            end else if (!(({1'b0, idx_reg} < watermark_reg) && word.in_use)) begin
                // entries at or above the watermark were never handed out
                m_data_next.status = STATUS_NOT_IN_USE;
            end else begin
                // push onto the list
                wr.en           = fire;
                wr.addr         = idx_reg;
                wr.data.in_use  = 1'b0;
                wr.data.link    = head_reg;
                head_next       = idx_reg;
                nonempty_next   = 1'b1;
                free_total_next = free_total_reg + COUNT_W'(1);
            end
        end
        m_data_next.available_count = free_total_next;
        m_data_next.used_count      = block_count_reg - free_total_next;
    end

    // state, pool registers and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            block_count_reg <= CAP;
            head_reg        <= '0;
            nonempty_reg    <= 1'b0;
            watermark_reg   <= '0;
            free_total_reg  <= CAP;
            m_valid_reg     <= 1'b0;
        end else begin
            if (accept) begin
                state_reg <= ST_EXEC;
                op_reg    <= s_data.opcode;
                idx_reg   <= s_data.block_index;
            end
            if (fire) begin
                state_reg      <= ST_IDLE;
                head_reg       <= head_next;
                nonempty_reg   <= nonempty_next;
                watermark_reg  <= watermark_next;
                free_total_reg <= free_total_next;
                m_valid_reg    <= 1'b1;
                m_data_reg     <= m_data_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            // reinitialize the pool on a block count write
            if (cfg_wr_en) begin
                block_count_reg <= cfg_count;
                head_reg        <= '0;
                nonempty_reg    <= 1'b0;
                watermark_reg   <= '0;
                free_total_reg  <= cfg_count;
            end
        end
    end

endmodule

@@ design/fbpa_ram.sv @@
// block table memory: one write port, one registered read port
module fbpa_ram
    import fbpa_pkg::*;
(
    input  logic               aclk,
    input  logic               rd_en,
    input  logic [INDEX_W-1:0] rd_addr,
    input  blk_wr_t            wr,
    output blk_word_t          rd_data
);

    blk_word_t mem [INDEX_SPACE];
    blk_word_t rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read port, registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/fbpa_checker.sv @@
// port-level checks of the allocator, bound to the top level
`include "assert_macros.svh"

module fbpa_checker
    import fbpa_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_beat_t m_data
);

    logic [COUNT_W:0] count_sum;
    logic             failed;
    logic             stalled;

    assign count_sum = {1'b0, m_data.available_count} + {1'b0, m_data.used_count};
    assign failed    = m_valid && (m_data.status != STATUS_OK);
    assign stalled   = m_valid && !m_ready;

    // free and used blocks never exceed the index space
    `ASSERT_CLK(a_count_sum, m_valid |-> (count_sum <= 10'd256), "counts exceed pool size")

    // a failed request carries index zero
    `ASSERT_CLK(a_grant_zero, failed |-> (m_data.granted_index == '0), "index on a failed request")

    // a stalled result beat holds
    `ASSERT_CLK(a_out_hold, stalled |=> (m_valid && $stable(m_data)), "stalled result beat changed")

    // no result beat right after reset
    `ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (.*);
